// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Command and status codes, field widths and the per-cell entry record.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int VAL_W = 32;
  localparam int PRI_W = 16;
  localparam int STS_W = 2;
  localparam int OCC_W = 5;

  // command codes carried in s_tuser
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // result status codes
  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

  // one queue entry as held in a cell
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic        [PRI_W-1:0] prio;
  } entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic                    enq;
    logic                    deq;
    logic signed [VAL_W-1:0] value;
    logic        [PRI_W-1:0] prio;
  } op_t;

endpackage

`default_nettype wire

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift register
// Holds one entry, takes the new item or its left neighbor on insert and
// its right neighbor on removal of the head.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire spq_pkg::op_t    op,
  input  wire spq_pkg::entry_t left_entry,
  input  wire logic            left_ins,
  input  wire spq_pkg::entry_t right_entry,
  output spq_pkg::entry_t      entry,
  output logic                 ins
);
  import spq_pkg::*;

  entry_t entry_next;

  // the new item goes ahead of this entry if the slot is free or strictly later
  assign ins = !entry.valid || (entry.prio > op.prio);

  // pick the incoming entry for this slot
  always_comb begin
    entry_next = entry;
    if (op.enq && ins) begin
      if (left_ins) begin
        entry_next = left_entry;
      end else begin
        entry_next.valid = 1'b1;
        entry_next.value = op.value;
        entry_next.prio  = op.prio;
      end
    end else if (op.deq) begin
      entry_next = right_entry;
    end
  end

  // clear the valid bit under reset, advance the payload
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.value <= entry_next.value;
    entry.prio  <= entry_next.prio;
  end

endmodule

`default_nettype wire

// ===== sv/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue in a sorted row of cells
// Smallest priority leaves first, equal priorities in arrival order.
// Result: the result word is registered from the accepted input word.
// Throughput: one word per cycle while m_tready is high; every cell compares
//   against the broadcast item and shifts with its neighbor in the same cycle.
// Reset: synchronous, clears all cell valid bits, the count and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // item_value[31:0], item_priority[47:32]
  input  wire logic        s_tuser,  // cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata   // out_value[31:0], status[33:32],
                                     // occupancy[38:34], zero [39]
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              op;
  entry_t           cells [DEPTH];
  logic             ins   [DEPTH];
  logic             fire;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [STS_W-1:0] sts;
  logic [VAL_W-1:0] res_value;

  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;
  assign full     = cells[DEPTH-1].valid;
  assign empty    = !cells[0].valid;

  // broadcast the operation to the row
  assign op.enq   = fire && (s_tuser == CMD_ENQ) && !full;
  assign op.deq   = fire && (s_tuser == CMD_DEQ) && !empty;
  assign op.value = s_tdata[VAL_W-1:0];
  assign op.prio  = s_tdata[VAL_W+PRI_W-1:VAL_W];

  // chain of cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_i;

    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_i = 1'b0;
    end else begin : g_mid
      assign left_e = cells[i-1];
      assign left_i = ins[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cells[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .left_entry  (left_e),
      .left_ins    (left_i),
      .right_entry (right_e),
      .entry       (cells[i]),
      .ins         (ins[i])
    );
  end

  // occupancy and result selection
  always_comb begin
    count_next = count;
    sts        = STS_OK;
    res_value  = '0;
    if (s_tuser == CMD_ENQ) begin
      if (full) begin
        sts = STS_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        sts = STS_EMPTY;
      end else begin
        count_next = count - CNT_W'(1);
        res_value  = cells[0].value;
      end
    end
  end

  // hold the count and the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (fire) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
        m_tdata  <= {1'b0, OCC_W'(count_next), sts, res_value};
      end
    end
  end

endmodule

`default_nettype wire
